@@ src/ils_pkg.sv @@
// Shared types and codes for the indexed list store.
package ils_pkg;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_FRONT  = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_INS_AT = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pos;
        logic [31:0] value;
    } t_cell_ctl;

endpackage

@@ src/ils_cell.sv @@
// One list slot: holds an entry and shifts it to or from its neighbors.
module ils_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic               i_clk,
    input  ils_pkg::t_cell_ctl i_ctl,
    input  logic [31:0]        i_left,
    input  logic [31:0]        i_right,
    output logic [31:0]        o_value,
    output logic [31:0]        o_read
);

    localparam logic [15:0] MY_POS = 16'(IDX);

    logic [31:0] r_val;
    logic [31:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            ils_pkg::OP_INSERT: begin
                if (MY_POS > i_ctl.pos) begin
                    n_val = i_left;
                end else if (MY_POS == i_ctl.pos) begin
                    n_val = i_ctl.value;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (MY_POS >= i_ctl.pos) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_read  = (MY_POS == i_ctl.pos) ? r_val : 32'd0;

endmodule

@@ src/indexed_list_store_top.sv @@
// Top level of the indexed list store: command decode, cell row and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries.
// Each item on the s_axis channel is one command: read at a position, insert
// at the front, append, insert before a position, or delete at a position.
// Each command gives exactly one item on the m_axis channel with the read
// value, a read valid flag, a status code and the list length afterwards.
// The entries live in a row of cells; an insert or delete shifts every later
// cell by one place in the same clock, so one command is taken per cycle.
// The result is loaded into the output register at the edge that accepts
// the command. Throughput is one item per cycle while
// the receiver keeps m_axis_tready high. When the receiver stalls, the
// result waits in the output register and s_axis_tready drops until it is
// taken; a new command is accepted in the same cycle the held result leaves.
// Reset empties the list and clears the output valid flag; the entries
// themselves are not cleared, since only positions below the length are read.
module indexed_list_store_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // command[2:0], position[18:3], value[50:19]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_value[31:0], read_valid[32], status[34:33],
                                       // list_length[39:35]
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [2:0]  w_cmd;
    logic [15:0] w_pos;
    logic [31:0] w_val;
    logic        w_accept;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [39:0]   r_out_data;

    logic [15:0]   w_count16;
    logic [15:0]   w_ins_pos;
    logic [1:0]    w_op;
    logic [1:0]    w_status;
    logic          w_rvalid;
    logic [31:0]   w_rvalue;
    logic [31:0]   w_len_ext;
    logic [31:0]   w_rd_bus;

    ils_pkg::t_cell_ctl w_ctl;

    logic [31:0] w_cell_val [CAPACITY];
    logic [31:0] w_cell_rd  [CAPACITY];

    assign w_cmd    = s_axis_tdata[2:0];
    assign w_pos    = s_axis_tdata[18:3];
    assign w_val    = s_axis_tdata[50:19];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_count16 = 16'(r_count);

    always_comb begin
        case (w_cmd)
            ils_pkg::CMD_FRONT:  w_ins_pos = 16'd0;
            ils_pkg::CMD_APPEND: w_ins_pos = w_count16;
            default:             w_ins_pos = w_pos;
        endcase
    end

    always_comb begin
        w_op     = ils_pkg::OP_HOLD;
        w_status = ils_pkg::ST_IGNORED;
        w_rvalid = 1'b0;
        w_rvalue = 32'd0;
        n_count  = r_count;
        case (w_cmd)
            ils_pkg::CMD_READ: begin
                if (w_pos < w_count16) begin
                    w_rvalue = w_rd_bus;
                    w_rvalid = 1'b1;
                    w_status = ils_pkg::ST_DONE;
                end else begin
                    w_rvalue = '1;
                end
            end
            ils_pkg::CMD_FRONT, ils_pkg::CMD_APPEND, ils_pkg::CMD_INS_AT: begin
                if (w_ins_pos <= w_count16) begin
                    if (r_count >= CAP) begin
                        w_status = ils_pkg::ST_FULL;
                    end else begin
                        w_op     = ils_pkg::OP_INSERT;
                        n_count  = r_count + CW'(1);
                        w_status = ils_pkg::ST_DONE;
                    end
                end
            end
            ils_pkg::CMD_DELETE: begin
                if (w_pos < w_count16) begin
                    w_op     = ils_pkg::OP_DELETE;
                    n_count  = r_count - CW'(1);
                    w_status = ils_pkg::ST_DONE;
                end
            end
            default: begin
                w_status = ils_pkg::ST_IGNORED;
            end
        endcase
    end

    assign w_ctl.op    = w_accept ? w_op : ils_pkg::OP_HOLD;
    assign w_ctl.pos   = w_ins_pos;
    assign w_ctl.value = w_val;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ils_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_cell_val[(g == 0) ? 0 : g - 1]),
            .i_right (w_cell_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value (w_cell_val[g]),
            .o_read  (w_cell_rd[g])
        );
    end

    always_comb begin
        w_rd_bus = 32'd0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_bus = w_rd_bus | w_cell_rd[i];
        end
    end

    assign w_len_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {w_len_ext[4:0], w_status, w_rvalid, w_rvalue};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("list length exceeds capacity");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> r_count == $past(r_count))
        else $error("list length changed without a command");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> m_axis_tdata[34:33] == ils_pkg::ST_DONE)
        else $error("valid read without done status");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == ils_pkg::ST_FULL) |-> r_count == CAP)
        else $error("insert refused while list not full");

endmodule
